FILE: hw/rtl/msd_pkg.sv
// Package for the Morse stream decoder: item types, character and kind codes,
// the Morse letter tree. No dependencies.
`default_nettype none
package msd_pkg;

  // Width of the running dot and dash counters (valid range 8..32).
  localparam int COUNT_BITS = 16;
  localparam int TOTAL_W    = 16;
  localparam int NODE_W     = 5;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_E     = 8'h45;  // 'E'
  localparam logic [7:0] CHAR_T     = 8'h54;  // 'T'

  localparam logic [2:0] KIND_LETTER   = 3'd0;
  localparam logic [2:0] KIND_WORD     = 3'd1;
  localparam logic [2:0] KIND_BAD_CHAR = 3'd2;
  localparam logic [2:0] KIND_BAD_CODE = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [7:0] symbol;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         character;
    logic [2:0]         kind;
    logic [TOTAL_W-1:0] dot_total;
    logic [TOTAL_W-1:0] dash_total;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic                  too_long;
    logic                  prev_space;
    logic                  skip;
    logic                  in_error;
    logic [COUNT_BITS-1:0] dot_cnt;
    logic [COUNT_BITS-1:0] dash_cnt;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    node: NODE_ROOT, too_long: 1'b0, prev_space: 1'b0, skip: 1'b0,
    in_error: 1'b0, dot_cnt: '0, dash_cnt: '0
  };

  // Letter at each heap index of the tree; zero where no letter sits.
  function automatic logic [7:0] morse_letter(input logic [NODE_W-1:0] n);
    logic [7:0] c;
    case (n)
      5'd2:    c = CHAR_E;
      5'd3:    c = CHAR_T;
      5'd4:    c = 8'h49;  // I
      5'd5:    c = 8'h41;  // A
      5'd6:    c = 8'h4E;  // N
      5'd7:    c = 8'h4D;  // M
      5'd8:    c = 8'h53;  // S
      5'd9:    c = 8'h55;  // U
      5'd10:   c = 8'h52;  // R
      5'd11:   c = 8'h57;  // W
      5'd12:   c = 8'h44;  // D
      5'd13:   c = 8'h4B;  // K
      5'd14:   c = 8'h47;  // G
      5'd15:   c = 8'h4F;  // O
      5'd16:   c = 8'h48;  // H
      5'd17:   c = 8'h56;  // V
      5'd18:   c = 8'h46;  // F
      5'd20:   c = 8'h4C;  // L
      5'd22:   c = 8'h50;  // P
      5'd23:   c = 8'h4A;  // J
      5'd24:   c = 8'h42;  // B
      5'd25:   c = 8'h58;  // X
      5'd26:   c = 8'h43;  // C
      5'd27:   c = 8'h59;  // Y
      5'd28:   c = 8'h5A;  // Z
      5'd29:   c = 8'h51;  // Q
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Saturating add of a small symbol count.
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] cnt,
                                                    input logic [2:0] add);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, cnt} + (COUNT_BITS+1)'(add);
    return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/msd_core.sv
// Next-state and result logic for one character of the Morse stream decoder.
// Purely combinational; depends on msd_pkg.
`default_nettype none
module msd_core (
  input  wire msd_pkg::dec_state_t st,
  input  wire msd_pkg::in_item_t   item,
  output msd_pkg::dec_state_t      st_nxt,
  output logic                     res_valid,
  output msd_pkg::out_item_t       res
);

  localparam int NODE_W_L = msd_pkg::NODE_W;

  logic       do_end;
  logic [7:0] letter;
  logic [2:0] depth;
  logic [2:0] dashes;
  logic [2:0] dots;
  logic [NODE_W_L-1:0] n;

  always_comb begin
    st_nxt        = st;
    res_valid     = 1'b0;
    res.character = 8'h00;
    res.kind      = msd_pkg::KIND_END;
    do_end        = 1'b0;

    if (st.in_error) begin
      // dropped until message end
    end else if (st.skip) begin
      st_nxt.skip       = 1'b0;
      st_nxt.prev_space = 1'b0;
    end else if (item.symbol == msd_pkg::CHAR_DOT || item.symbol == msd_pkg::CHAR_DASH) begin
      if (st.node[NODE_W_L-1]) begin
        st_nxt.too_long = 1'b1;
      end else begin
        st_nxt.node = {st.node[NODE_W_L-2:0], (item.symbol == msd_pkg::CHAR_DASH)};
      end
      st_nxt.prev_space = 1'b0;
    end else if (item.symbol == msd_pkg::CHAR_SPACE) begin
      do_end            = 1'b1;
      st_nxt.prev_space = 1'b1;
    end else if (item.symbol == msd_pkg::CHAR_SLASH && st.prev_space) begin
      res_valid         = 1'b1;
      res.kind          = msd_pkg::KIND_WORD;
      res.character     = msd_pkg::CHAR_SPACE;
      st_nxt.skip       = 1'b1;
      st_nxt.prev_space = 1'b0;
    end else begin
      res_valid         = 1'b1;
      res.kind          = msd_pkg::KIND_BAD_CHAR;
      st_nxt.in_error   = 1'b1;
      st_nxt.prev_space = 1'b0;
      st_nxt.node       = msd_pkg::NODE_ROOT;
      st_nxt.too_long   = 1'b0;
    end

    // Message end flushes a pending code when nothing else came out.
    if (item.message_end && !res_valid && !st_nxt.in_error) begin
      do_end = 1'b1;
    end

    // Letter end, evaluated on the code after this character's step.
    n      = st_nxt.node;
    letter = msd_pkg::morse_letter(n);
    depth  = n[4] ? 3'd4 : n[3] ? 3'd3 : n[2] ? 3'd2 : 3'd1;
    dashes = 3'($countones(n)) - 3'd1;
    dots   = depth - dashes;
    if (do_end) begin
      if (n[NODE_W_L-1:1] == '0 && !st_nxt.too_long) begin
        // empty code: nothing
      end else if (st_nxt.too_long || letter == 8'h00) begin
        res_valid       = 1'b1;
        res.kind        = msd_pkg::KIND_BAD_CODE;
        st_nxt.in_error = 1'b1;
      end else begin
        res_valid       = 1'b1;
        res.kind        = msd_pkg::KIND_LETTER;
        res.character   = letter;
        st_nxt.dot_cnt  = msd_pkg::sat_add(st_nxt.dot_cnt, dots);
        st_nxt.dash_cnt = msd_pkg::sat_add(st_nxt.dash_cnt, dashes);
      end
      st_nxt.node     = msd_pkg::NODE_ROOT;
      st_nxt.too_long = 1'b0;
    end

    if (item.message_end && !res_valid) begin
      res_valid     = 1'b1;
      res.kind      = msd_pkg::KIND_END;
      res.character = 8'h00;
    end

    res.dot_total    = msd_pkg::TOTAL_W'(st_nxt.dot_cnt);
    res.dash_total   = msd_pkg::TOTAL_W'(st_nxt.dash_cnt);
    res.final_result = item.message_end;

    if (item.message_end) begin
      st_nxt = msd_pkg::STATE_RESET;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/msd_skid.sv
// Output register plus one skid entry for the decoder's result channel.
// Depends on msd_pkg.
`default_nettype none
module msd_skid (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire msd_pkg::out_item_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire                    out_ready,
  output msd_pkg::out_item_t     out_data
);

  logic               out_v_r;
  logic               skid_v_r;
  msd_pkg::out_item_t out_d_r;
  msd_pkg::out_item_t skid_d_r;
  logic               drain;

  assign drain     = !out_v_r || out_ready;
  assign space     = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r && drain) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else if (drain) begin
      out_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r && drain) begin
      out_d_r <= skid_d_r;
    end else if (drain) begin
      out_d_r <= push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/morse_stream_decoder.sv
// Top level of the Morse stream decoder: state registers, core logic and
// result buffering. Depends on msd_pkg, msd_core and msd_skid.
`default_nettype none
// The decoder takes one ASCII character per item ('.', '-', ' ', '/') with a
// message_end flag and gives at most one result item per input item: a
// letter, a word space, an error, or an end-only marker on the last character.
// The character and the stored tree index meet in one pass of logic, and the
// result is written on the edge that accepts the item: into the output register,
// or into the skid entry when the output register holds a result not yet taken.
// A new item can be accepted every cycle while in_ready is high. A one-entry
// skid stage behind the output register lets one more item in while a result
// waits; in_ready drops only when both are full. Dot and dash totals saturate
// and clear at message end, along with all other state.
module morse_stream_decoder (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire msd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output msd_pkg::out_item_t      out_data
);

  msd_pkg::dec_state_t st_r;
  msd_pkg::dec_state_t st_nxt;
  msd_pkg::out_item_t  res;
  logic                res_valid;
  logic                accept;
  logic                space;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  // Character decode: tree walk, letter end, totals and error tracking.
  msd_core u_core (
    .st        (st_r),
    .item      (in_data),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= msd_pkg::STATE_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Output register and skid entry.
  msd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_end_implies_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == msd_pkg::KIND_END |-> out_data.final_result)
    else $error("end-only result without final flag");

  a_word_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == msd_pkg::KIND_WORD
      |-> out_data.character == msd_pkg::CHAR_SPACE)
    else $error("word space result with wrong character");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.message_end |=> st_r == msd_pkg::STATE_RESET)
    else $error("state not cleared after message end");

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.message_end |-> res_valid)
    else $error("final character produced no result");
`endif

endmodule
`default_nettype wire
